### sv/psfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfc_pkg: shared types, constants and functions of the sample converter
// Format codes, scaling constants and the small arithmetic helpers used by
// the conversion and quantiser stages.
// ----------------------------------------------------------------------------
package psfc_pkg;

    // native sample encodings
    typedef enum logic [1:0] {
        FMT_U8   = 2'd0,
        FMT_U16  = 2'd1,
        FMT_HALF = 2'd2,
        FMT_F32  = 2'd3
    } t_fmt;

    // significands of float(1/255) and float(1/65535)
    localparam logic [23:0] INV255_MANT   = 24'h808081;
    localparam logic [23:0] INV65535_MANT = 24'h800080;

    // biased exponent of the product = lead + 127 - scale
    localparam logic [7:0] U8_EXP_BIAS  = 8'd96;   // scale 2^-31
    localparam logic [7:0] U16_EXP_BIAS = 8'd88;   // scale 2^-39

    localparam logic [31:0] FLOAT_ONE = 32'h3F80_0000;

    // position of the highest set bit (0 when none)
    function automatic logic [5:0] lead_one(input logic [39:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < 40; i++) begin
            if (v[i]) p = 6'(i);
        end
        return p;
    endfunction

    // shift right by s, rounding to nearest even
    function automatic logic [40:0] rne_shift(input logic [39:0] v, input logic [5:0] s);
        logic [39:0] q;
        logic [39:0] mask;
        logic [39:0] rem;
        logic [39:0] half;
        logic        up;
        q    = v >> s;
        mask = (40'd1 << s) - 40'd1;
        rem  = v & mask;
        half = (s == 6'd0) ? 40'd0 : (40'd1 << (s - 6'd1));
        up   = (s != 6'd0) && ((rem > half) || ((rem == half) && q[0]));
        return {1'b0, q} + 41'(up);
    endfunction

    // exact half to single widening
    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic        sgn;
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [3:0]  shn;
        logic [10:0] mn;
        logic [31:0] r;
        sgn = h[15];
        ex  = h[14:10];
        man = h[9:0];
        p   = '0;
        for (int i = 0; i < 10; i++) begin
            if (man[i]) p = 4'(i);
        end
        shn = 4'd10 - p;
        mn  = 11'(man) << shn;
        if (ex == 5'd0) begin
            if (man == 10'd0) r = {sgn, 31'd0};
            else r = {sgn, 8'd103 + 8'(p), mn[9:0], 13'd0};
        end else if (ex == 5'h1f) begin
            r = {sgn, 8'hff, man, 13'd0};
        end else begin
            r = {sgn, 8'(ex) + 8'd112, man, 13'd0};
        end
        return r;
    endfunction

endpackage

### sv/psfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfc_if: stream channels of the sample converter
// Valid/ready channels for incoming samples and outgoing results.
// ----------------------------------------------------------------------------
interface psfc_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample;
    logic        last_in;

    modport source (output valid, output sample, output last_in, input ready);
    modport sink   (input valid, input sample, input last_in, output ready);
endinterface

interface psfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value_float;
    logic [7:0]  value_byte;
    logic        last_out;

    modport source (output valid, output value_float, output value_byte,
                    output last_out, input ready);
    modport sink   (input valid, input value_float, input value_byte,
                    input last_out, output ready);
endinterface

### sv/psfc_quant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psfc_quant: three-stage float to byte quantiser
// Clamps to [0,1], multiplies by 255, adds one half and truncates, with each
// float operation rounded to nearest even. NaN and negatives give zero.
// ----------------------------------------------------------------------------
module psfc_quant (
    input  logic        i_clk,
    input  logic [2:0]  i_en,
    input  logic [31:0] i_x,
    output logic [7:0]  o_byte
);

    // stage 1: clamp and multiply significand by 255
    logic [31:0] n_xc;
    logic [23:0] n_m;
    logic [7:0]  n_e;
    logic        n_kill;
    logic [31:0] r_prod;
    logic [7:0]  r_exp;
    logic        r_kill;

    always_comb begin
        n_kill = i_x[31] || ((i_x[30:23] == 8'hff) && (i_x[22:0] != 23'd0));
        n_xc   = (i_x[30:0] > psfc_pkg::FLOAT_ONE[30:0]) ? psfc_pkg::FLOAT_ONE : i_x;
        n_m    = (n_xc[30:23] == 8'd0) ? {1'b0, n_xc[22:0]} : {1'b1, n_xc[22:0]};
        n_e    = (n_xc[30:23] == 8'd0) ? 8'd1 : n_xc[30:23];
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_prod <= 32'(n_m) * 32'd255;
            r_exp  <= n_e;
            r_kill <= n_kill;
        end
    end

    // stage 2: round product to 24 bits, align to 25 fraction bits
    logic [5:0]  n_lead;
    logic [5:0]  n_sh;
    logic [40:0] n_rnd;
    logic [32:0] n_pr;
    logic [7:0]  n_rs;
    logic [32:0] n_t;
    logic [32:0] r_t;
    logic        r_kill2;

    always_comb begin
        n_lead = psfc_pkg::lead_one({8'd0, r_prod});
        n_sh   = (r_prod < 32'h0100_0000) ? 6'd0 : (n_lead - 6'd23);
        n_rnd  = psfc_pkg::rne_shift({8'd0, r_prod}, n_sh);
        n_pr   = 33'(n_rnd << n_sh);
        n_rs   = 8'd125 - r_exp;
        if (r_exp >= 8'd125) n_t = n_pr << (r_exp - 8'd125);
        else if (n_rs >= 8'd34) n_t = '0;
        else n_t = n_pr >> n_rs;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_t     <= n_t;
            r_kill2 <= r_kill;
        end
    end

    // stage 3: add one half, round, truncate to byte
    logic [33:0] n_s;
    logic [5:0]  n_lead3;
    logic [5:0]  n_sh3;
    logic [40:0] n_rnd3;
    logic [40:0] n_r3;

    always_comb begin
        n_s     = 34'(r_t) + 34'h100_0000;
        n_lead3 = psfc_pkg::lead_one({6'd0, n_s});
        n_sh3   = n_lead3 - 6'd23;
        n_rnd3  = psfc_pkg::rne_shift({6'd0, n_s}, n_sh3);
        n_r3    = n_rnd3 << n_sh3;
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            if (r_kill2 || (r_t < 33'h080_0000)) o_byte <= 8'd0;
            else o_byte <= n_r3[32:25];
        end
    end

endmodule

### sv/pixel_sample_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_sample_format_converter: sample to normalised float and byte
// Converts uint8, uint16, half or single samples to a single-precision value
// in the normalised range and an 8-bit quantised value.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake     | payload
//  i_in      | in  | valid/ready   | sample[31:0], last_in
//  o_out     | out | valid/ready   | value_float[31:0], value_byte[7:0], last_out
//  i_cfg_*   | in  | write enable  | sample format[1:0]
//
// Five register stages, one beat per cycle while the receiver is ready.
// Each stage holds while its successor is full and cannot advance; bubbles close up under a stall.
// Reset empties the pipe and sets the format to uint8.
// The format is captured with each beat as it enters.
// ----------------------------------------------------------------------------
module pixel_sample_format_converter (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_wdata,
    psfc_in_if.sink          i_in,
    psfc_out_if.source       o_out
);

    logic [4:0]  r_vld;
    logic [4:0]  en;
    psfc_pkg::t_fmt r_fmt;

    // stall chain
    always_comb begin
        en[4] = !r_vld[4] || o_out.ready;
        for (int k = 3; k >= 0; k--) en[k] = !r_vld[k] || en[k + 1];
    end
    assign i_in.ready = en[0];

    // config register and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= psfc_pkg::FMT_U8;
            r_vld <= '0;
        end else begin
            if (i_cfg_we) r_fmt <= psfc_pkg::t_fmt'(i_cfg_wdata);
            if (en[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < 5; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k - 1];
            end
        end
    end

    // stage 0: integer scaling product and half widening
    logic [15:0] n_int;
    logic [23:0] n_mant;
    logic [39:0] r0_prod;
    logic [31:0] r0_half;
    logic [31:0] r0_raw;
    psfc_pkg::t_fmt r0_fmt;
    logic        r0_last;

    always_comb begin
        n_int  = (r_fmt == psfc_pkg::FMT_U8) ? {8'd0, i_in.sample[7:0]} : i_in.sample[15:0];
        n_mant = (r_fmt == psfc_pkg::FMT_U8) ? psfc_pkg::INV255_MANT
                                            : psfc_pkg::INV65535_MANT;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_prod <= 40'(n_int) * 40'(n_mant);
            r0_half <= psfc_pkg::widen_half(i_in.sample[15:0]);
            r0_raw  <= i_in.sample;
            r0_fmt  <= r_fmt;
            r0_last <= i_in.last_in;
        end
    end

    // stage 1: normalise and round the product, select float
    logic [5:0]  n_lead;
    logic [5:0]  n_sh;
    logic [40:0] n_rnd;
    logic [7:0]  n_exp;
    logic [31:0] n_float;

    always_comb begin
        n_lead = psfc_pkg::lead_one(r0_prod);
        n_sh   = n_lead - 6'd23;
        n_rnd  = psfc_pkg::rne_shift(r0_prod, n_sh);
        n_exp  = 8'(n_lead) + 8'(n_rnd[24])
               + ((r0_fmt == psfc_pkg::FMT_U8) ? psfc_pkg::U8_EXP_BIAS
                                              : psfc_pkg::U16_EXP_BIAS);
        case (r0_fmt)
            psfc_pkg::FMT_U8, psfc_pkg::FMT_U16: begin
                n_float = (r0_prod == 40'd0) ? 32'd0 : {1'b0, n_exp, n_rnd[22:0]};
            end
            psfc_pkg::FMT_HALF: n_float = r0_half;
            default:            n_float = r0_raw;
        endcase
    end

    logic [31:0]    r_float [1:4];
    logic [7:0]     r_raw   [1:4];
    psfc_pkg::t_fmt r_pfmt  [1:4];
    logic           r_last  [1:4];

    // stage 1 load, then carry alongside the quantiser
    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_float[1] <= n_float;
            r_raw[1]   <= r0_raw[7:0];
            r_pfmt[1]  <= r0_fmt;
            r_last[1]  <= r0_last;
        end
        for (int k = 2; k < 5; k++) begin
            if (en[k]) begin
                r_float[k] <= r_float[k - 1];
                r_raw[k]   <= r_raw[k - 1];
                r_pfmt[k]  <= r_pfmt[k - 1];
                r_last[k]  <= r_last[k - 1];
            end
        end
    end

    // stages 2..4: quantiser
    logic [7:0] q_byte;

    psfc_quant u_quant (
        .i_clk  (i_clk),
        .i_en   (en[4:2]),
        .i_x    (r_float[1]),
        .o_byte (q_byte)
    );

    // output beat
    assign o_out.valid       = r_vld[4];
    assign o_out.value_float = r_float[4];
    assign o_out.value_byte  = (r_pfmt[4] == psfc_pkg::FMT_U8) ? r_raw[4] : q_byte;
    assign o_out.last_out    = r_last[4];

`ifndef ASSERT_OFF
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> r_vld == 5'd0)
        else $error("pipe not empty after reset");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((&r_vld) && !o_out.ready) |-> !i_in.ready)
        else $error("accepted beat into a full stalled pipe");
    a_u8_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_pfmt[4] == psfc_pkg::FMT_U8 && o_out.value_byte == 8'hff)
        |-> o_out.value_float == psfc_pkg::FLOAT_ONE)
        else $error("full-scale byte did not give 1.0");
    a_nan_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && r_pfmt[4] != psfc_pkg::FMT_U8
         && o_out.value_float[30:23] == 8'hff && o_out.value_float[22:0] != 23'd0)
        |-> o_out.value_byte == 8'd0)
        else $error("NaN did not quantise to zero");
`endif

endmodule

### verif/tb_pixel_sample_format_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_sample_format_converter: self-checking bench of the sample converter
// Streams samples in all four native formats through the block under random
// sender bursts and receiver stalls. A bit-exact integer model of the float
// scaling, half widening and byte quantiser predicts every result beat, which
// is checked in order against the output channel.
// ----------------------------------------------------------------------------
module tb_pixel_sample_format_converter;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [31:0] value_float;
        logic [7:0]  value_byte;
        logic        last_out;
    } t_conv_result;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_wdata;

    psfc_in_if  in_ch ();
    psfc_out_if out_ch ();

    pixel_sample_format_converter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    t_conv_result   results_due[$];
    psfc_pkg::t_fmt fmt_now;
    int             mismatches;
    int             cycle_count;
    int             stall_pct;
    int             hold_req;
    int             hold_left;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // round n * 2^k to single precision, nearest even; value = m * 2^e
    function automatic void round_single(input logic [191:0] n, input int k,
                                         output logic [23:0] m, output int e);
        int          lead;
        int          tgt;
        int          s;
        logic [191:0] q;
        logic [191:0] rem;
        logic [191:0] half;
        lead = -1;
        for (int i = 0; i < 192; i++) begin
            if (n[i]) lead = i;
        end
        if (lead < 0) begin
            m = '0;
            e = -149;
            return;
        end
        tgt = k + lead - 23;
        if (tgt < -149) tgt = -149;
        s = tgt - k;
        if (s <= 0) begin
            q = n << (-s);
        end else begin
            q    = n >> s;
            rem  = n & ((192'd1 << s) - 192'd1);
            half = 192'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q = q + 192'd1;
            if (q[24]) begin
                q   = q >> 1;
                tgt = tgt + 1;
            end
        end
        m = q[23:0];
        e = tgt;
    endfunction

    // positive single from m * 2^e (normal or subnormal)
    function automatic logic [31:0] pack_single(input logic [23:0] m, input int e);
        if (m == '0) return 32'd0;
        if (m[23]) return {1'b0, 8'(e + 150), m[22:0]};
        return {1'b0, 8'd0, m[22:0]};
    endfunction

    // exact half to single widening
    function automatic logic [31:0] half_to_single(input logic [15:0] h);
        logic [10:0] man;
        logic [7:0]  ex;
        man = {1'b0, h[9:0]};
        if (h[14:10] == 5'd0) begin
            if (man == '0) return {h[15], 31'd0};
            ex = 8'd113;
            for (int i = 0; i < 11 && !man[10]; i++) begin
                man = man << 1;
                ex  = ex - 8'd1;
            end
            return {h[15], ex, man[9:0], 13'd0};
        end
        if (h[14:10] == 5'h1f) return {h[15], 8'hff, h[9:0], 13'd0};
        return {h[15], 8'(h[14:10]) + 8'd112, h[9:0], 13'd0};
    endfunction

    // clamp to [0,1], times 255, plus 0.5, truncate; each step rounded
    function automatic logic [7:0] quantise_byte(input logic [31:0] x);
        logic [23:0]  m;
        logic [23:0]  m2;
        logic [23:0]  m3;
        logic [191:0] n;
        int           e;
        int           e2;
        int           e3;
        int           mm;
        if (x[30:23] == 8'hff && x[22:0] != '0) return 8'd0;
        if (x[31]) return 8'd0;
        if (x > psfc_pkg::FLOAT_ONE) x = psfc_pkg::FLOAT_ONE;
        if (x[30:23] == 8'd0) begin
            m = {1'b0, x[22:0]};
            e = -149;
        end else begin
            m = {1'b1, x[22:0]};
            e = int'(x[30:23]) - 150;
        end
        round_single(192'(m) * 192'd255, e, m2, e2);
        mm = (e2 < -1) ? e2 : -1;
        n  = (192'(m2) << (e2 - mm)) + (192'd1 << (-1 - mm));
        round_single(n, mm, m3, e3);
        if (e3 >= 0) return 8'(32'(m3) << e3);
        return 8'(m3 >> (-e3));
    endfunction

    // expected conversion of one sample in the current format
    function automatic t_conv_result convert_sample(input logic [31:0] s, input logic last);
        t_conv_result r;
        logic [23:0]  m;
        int           e;
        r.last_out = last;
        case (fmt_now)
            psfc_pkg::FMT_U8: begin
                round_single(192'(s[7:0]) * 192'(psfc_pkg::INV255_MANT), -31, m, e);
                r.value_float = pack_single(m, e);
                r.value_byte  = s[7:0];
            end
            psfc_pkg::FMT_U16: begin
                round_single(192'(s[15:0]) * 192'(psfc_pkg::INV65535_MANT), -39, m, e);
                r.value_float = pack_single(m, e);
                r.value_byte  = quantise_byte(r.value_float);
            end
            psfc_pkg::FMT_HALF: begin
                r.value_float = half_to_single(s[15:0]);
                r.value_byte  = quantise_byte(r.value_float);
            end
            default: begin
                r.value_float = s;
                r.value_byte  = quantise_byte(s);
            end
        endcase
        return r;
    endfunction

    // offer one beat and hold it until accepted; returns at the next falling edge
    task automatic send_sample(input logic [31:0] s, input logic last);
        in_ch.valid   = 1'b1;
        in_ch.sample  = s;
        in_ch.last_in = last;
        do @(posedge i_clk); while (!in_ch.ready);
        results_due.push_back(convert_sample(s, last));
        @(negedge i_clk);
    endtask

    task automatic sender_gap(input int n);
        in_ch.valid = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (results_due.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_format(input psfc_pkg::t_fmt f);
        wait_drained();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = f;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        fmt_now  = f;
    endtask

    // random sample, for half and single biased towards the normalised range
    function automatic logic [31:0] rand_sample(input psfc_pkg::t_fmt f);
        logic [31:0] s;
        s = $urandom;
        if ($urandom_range(0, 2) != 0) begin
            if (f == psfc_pkg::FMT_HALF) s[15:10] = {1'b0, 5'($urandom_range(0, 15))};
            if (f == psfc_pkg::FMT_F32) s[31:23] = {1'b0, 8'($urandom_range(95, 127))};
        end
        return s;
    endfunction

    task automatic test_uint8();
        set_format(psfc_pkg::FMT_U8);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_00ff, 1'b1);
        send_sample(32'hffff_ff80, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
    endtask

    task automatic test_uint16();
        set_format(psfc_pkg::FMT_U16);
        send_sample(32'h0000_0000, 1'b0);
        send_sample(32'h0000_ffff, 1'b1);
        send_sample(32'hffff_8000, 1'b0);
        send_sample(32'h0000_0001, 1'b0);
    endtask

    task automatic test_half();
        set_format(psfc_pkg::FMT_HALF);
        send_sample(32'h0000_0000, 1'b0);   // +0
        send_sample(32'h0000_8000, 1'b0);   // -0
        send_sample(32'h0000_0001, 1'b0);   // smallest subnormal
        send_sample(32'hffff_03ff, 1'b0);   // largest subnormal, junk above
        send_sample(32'h0000_7c00, 1'b1);   // +inf
        send_sample(32'h0000_fc00, 1'b0);   // -inf
        send_sample(32'h0000_7e01, 1'b0);   // NaN with payload
        send_sample(32'h0000_3c00, 1'b0);   // one
        send_sample(32'h0000_7bff, 1'b0);   // largest finite
    endtask

    task automatic test_single();
        set_format(psfc_pkg::FMT_F32);
        send_sample(32'h8000_0000, 1'b0);   // -0
        send_sample(32'h7f80_0000, 1'b0);   // +inf
        send_sample(32'hff80_0000, 1'b0);   // -inf
        send_sample(32'h7fc0_0001, 1'b1);   // NaN
        send_sample(32'h3f80_0001, 1'b0);   // just above one
        send_sample(32'h0000_0001, 1'b0);   // subnormal
        send_sample(32'hbf80_0000, 1'b0);   // -1
        send_sample(32'h3b80_8081, 1'b0);   // about 1/255
    endtask

    // receiver held off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        set_format(psfc_pkg::FMT_F32);
        @(posedge i_clk);
        hold_req = 300;
        @(negedge i_clk);
        for (int i = 0; i < 60; i++) begin
            send_sample(rand_sample(psfc_pkg::FMT_F32), 1'($urandom));
        end
        wait_drained();
    endtask

    task automatic test_random();
        psfc_pkg::t_fmt order[8];
        int             burst;
        order = '{psfc_pkg::FMT_F32, psfc_pkg::FMT_U8, psfc_pkg::FMT_HALF, psfc_pkg::FMT_U16,
                  psfc_pkg::FMT_F32, psfc_pkg::FMT_HALF, psfc_pkg::FMT_U8, psfc_pkg::FMT_U16};
        foreach (order[p]) begin
            set_format(order[p]);
            burst = 0;
            for (int i = 0; i < 110; i++) begin
                if (burst == 0) begin
                    burst = $urandom_range(1, 20);
                    if (p % 4 != 1) sender_gap($urandom_range(0, 6));
                end
                send_sample(rand_sample(order[p]), 1'($urandom));
                burst--;
            end
        end
    endtask

    // stimulus
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        in_ch.valid   = 1'b0;
        in_ch.sample  = '0;
        in_ch.last_in = 1'b0;
        fmt_now       = psfc_pkg::FMT_U8;
        mismatches    = 0;
        hold_req      = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_uint8();
        test_uint16();
        test_half();
        test_single();
        test_backpressure();
        test_random();
        wait_drained();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // receiver ready pattern: changing stall rate, with long hold-offs on request
    initial begin
        out_ch.ready = 1'b0;
        stall_pct    = 0;
        hold_left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if ($urandom_range(0, 63) == 0) begin
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 80);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_conv_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat: float %h byte %h",
                                               out_ch.value_float, out_ch.value_byte);
            end else begin
                want = results_due.pop_front();
                if (out_ch.value_float !== want.value_float
                        || out_ch.value_byte !== want.value_byte
                        || out_ch.last_out !== want.last_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: float %h/%h byte %h/%h last %b/%b (exp/act)",
                                 want.value_float, out_ch.value_float,
                                 want.value_byte, out_ch.value_byte,
                                 want.last_out, out_ch.last_out);
                    end
                end
            end
        end
    end

endmodule

### files.f
sv/psfc_pkg.sv
sv/psfc_if.sv
sv/psfc_quant.sv
sv/pixel_sample_format_converter.sv
verif/tb_pixel_sample_format_converter.sv
